// ----- hw/rtl/jdzpa_pkg.sv -----
// Package: shared types, constants and the arctangent table for the joystick block.
package jdzpa_pkg;

  localparam int unsigned NORM_W   = 16;
  localparam int unsigned ANGLE_W  = 13;
  localparam int unsigned MID_W    = 10;
  localparam int unsigned BAND_W   = 8;
  localparam int unsigned FREE_W   = 8;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned ATAN_N   = 24;
  localparam int unsigned Z_W      = 27;
  localparam int unsigned CW_W     = 34;
  localparam int unsigned FULL_TURN = 5760;
  localparam int unsigned SERVO_MAX = 6120;

  localparam logic [IDX_W-1:0] REG_MID_X   = 2'd0;
  localparam logic [IDX_W-1:0] REG_MID_Y   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEAD    = 2'd2;
  localparam logic [IDX_W-1:0] REG_FREEDOM = 2'd3;

  typedef struct packed {
    logic [MID_W-1:0] x_sample;
    logic [MID_W-1:0] y_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x_norm;
    logic signed [NORM_W-1:0] y_norm;
    logic [ANGLE_W-1:0]       polar_angle;
    logic [ANGLE_W-1:0]       x_angle;
    logic [ANGLE_W-1:0]       y_angle;
  } out_item_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [Z_W-1:0] atan_lut(input int unsigned i);
    logic [Z_W-1:0] r;
    begin
      case (i)
        0: r = 27'd2949120;  1: r = 27'd1740967;  2: r = 27'd919879;
        3: r = 27'd466945;   4: r = 27'd234379;   5: r = 27'd117304;
        6: r = 27'd58666;    7: r = 27'd29335;    8: r = 27'd14668;
        9: r = 27'd7334;     10: r = 27'd3667;    11: r = 27'd1833;
        12: r = 27'd917;     13: r = 27'd458;     14: r = 27'd229;
        15: r = 27'd115;     16: r = 27'd57;      17: r = 27'd29;
        18: r = 27'd14;      19: r = 27'd7;       20: r = 27'd4;
        21: r = 27'd2;       22: r = 27'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hw/rtl/jdzpa_div.sv -----
// Pipelined restoring divider: quotient of num / den, one quotient bit per stage.
module jdzpa_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 11,
  parameter int unsigned Q_W   = 17,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic [TAG_W-1:0] tag_o
);
  // quotient bits from Q_W-1 down to 0; caller guarantees num < den << Q_W
  localparam int unsigned R_W = DEN_W + 1;

  logic                     vld_q  [1:Q_W];
  logic [R_W-1:0]           rem_q  [1:Q_W];
  logic [NUM_W-1:0]         num_q  [1:Q_W];
  logic [DEN_W-1:0]         den_q  [1:Q_W];
  logic [Q_W-1:0]           quo_q  [1:Q_W];
  logic [TAG_W-1:0]         tag_q  [1:Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int unsigned B = Q_W - 1 - s;
    logic             v_in;
    logic [NUM_W-1:0] n_in;
    logic [DEN_W-1:0] d_in;
    logic [Q_W-1:0]   q_in;
    logic [TAG_W-1:0] t_in;
    logic [R_W:0]     shifted_d;
    logic [R_W:0]     trial_d;
    logic             take_d;
    if (s == 0) begin : g_src
      // leading numerator bits form the first partial remainder
      assign v_in      = valid_i;
      assign n_in      = num_i;
      assign d_in      = den_i;
      assign q_in      = '0;
      assign t_in      = tag_i;
      assign shifted_d = (R_W+1)'(num_i >> B);
    end else begin : g_src
      assign v_in      = vld_q[s];
      assign n_in      = num_q[s];
      assign d_in      = den_q[s];
      assign q_in      = quo_q[s];
      assign t_in      = tag_q[s];
      assign shifted_d = {rem_q[s], num_q[s][B]};
    end
    always_comb begin
      trial_d = shifted_d - {2'b00, d_in};
      take_d  = (shifted_d >= {2'b00, d_in});
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= take_d ? R_W'(trial_d) : R_W'(shifted_d);
      num_q[s+1] <= n_in;
      den_q[s+1] <= d_in;
      quo_q[s+1] <= q_in | (Q_W'(take_d) << B);
      tag_q[s+1] <= t_in;
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quot_o  = quo_q[Q_W];
  assign tag_o   = tag_q[Q_W];
endmodule

// ----- hw/rtl/jdzpa_cordic.sv -----
// Pipelined vectoring CORDIC with pre-rotation, one micro-rotation per stage.
module jdzpa_cordic #(
  parameter int unsigned STEPS = 16,
  parameter int unsigned TAG_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [jdzpa_pkg::NORM_W-1:0] x_i,
  input  logic signed [jdzpa_pkg::NORM_W-1:0] y_i,
  input  logic [TAG_W-1:0]                 tag_i,
  output logic                             valid_o,
  output logic [jdzpa_pkg::ANGLE_W-1:0]    angle_o,
  output logic [TAG_W-1:0]                 tag_o
);
  localparam int unsigned V_W = 34;
  localparam int unsigned Z_W = 32;
  localparam int unsigned N   = (STEPS < jdzpa_pkg::ATAN_N) ? STEPS : jdzpa_pkg::ATAN_N;

  logic [N+1:0]            vld_q;
  logic signed [V_W-1:0]   x_q [N+1];
  logic signed [V_W-1:0]   y_q [N+1];
  logic signed [Z_W-1:0]   z_q [N+1];
  logic [1:0]              sp_q [N+1]; // 0 normal, 2 fixed (y or x zero)
  logic [TAG_W-1:0]        tag_q [N+1];

  // input conditioning (registered as stage 0)
  logic signed [V_W-1:0] xs_d, ys_d;
  logic signed [Z_W-1:0] z0_d;
  logic [1:0]            sp_d;
  always_comb begin
    xs_d = V_W'(x_i) <<< 12;
    ys_d = V_W'(y_i) <<< 12;
    z0_d = '0;
    sp_d = 2'd0;
    if (y_i == '0) begin
      sp_d = 2'd2;
      z0_d = (x_i < 0) ? Z_W'(180 * 65536) : '0;
    end else if (x_i == '0) begin
      sp_d = 2'd2;
      z0_d = (y_i > 0) ? Z_W'(90 * 65536) : Z_W'(270 * 65536);
    end else if (x_i < 0) begin
      xs_d = -xs_d;
      ys_d = -ys_d;
      z0_d = Z_W'(180 * 65536);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q[0] <= xs_d; y_q[0] <= ys_d; z_q[0] <= z0_d; sp_q[0] <= sp_d; tag_q[0] <= tag_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [V_W-1:0] xn_d, yn_d;
    logic signed [Z_W-1:0] zn_d;
    always_comb begin
      xn_d = x_q[i]; yn_d = y_q[i]; zn_d = z_q[i];
      if (sp_q[i] == 2'd0) begin
        if (y_q[i] >= 0) begin
          xn_d = x_q[i] + (y_q[i] >>> i);
          yn_d = y_q[i] - (x_q[i] >>> i);
          zn_d = z_q[i] + Z_W'(jdzpa_pkg::atan_lut(i));
        end else begin
          xn_d = x_q[i] - (y_q[i] >>> i);
          yn_d = y_q[i] + (x_q[i] >>> i);
          zn_d = z_q[i] - Z_W'(jdzpa_pkg::atan_lut(i));
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[i+1] <= xn_d; y_q[i+1] <= yn_d; z_q[i+1] <= zn_d;
      sp_q[i+1] <= sp_q[i]; tag_q[i+1] <= tag_q[i];
    end
  end

  // fold: wrap, round to 1/16 degree, make clockwise
  logic signed [Z_W-1:0] zw_d;
  logic [Z_W-1:0]        ccw_d;
  logic [13:0]           c_d;
  logic [jdzpa_pkg::ANGLE_W-1:0] ang_q;
  logic [TAG_W-1:0]      tago_q;
  always_comb begin
    zw_d = z_q[N];
    if (sp_q[N] == 2'd0 && zw_d < 0) zw_d = zw_d + Z_W'(360 * 65536);
    ccw_d = Z_W'((zw_d + Z_W'(2048)) >>> 12);
    c_d = 14'(ccw_d);
    if (c_d >= 14'(jdzpa_pkg::FULL_TURN)) c_d = c_d - 14'(jdzpa_pkg::FULL_TURN);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[N+1] <= 1'b0;
    end else begin
      vld_q[N+1] <= vld_q[N];
    end
  end
  always_ff @(posedge clk_i) begin
    if (sp_q[N] == 2'd1 || c_d == '0) ang_q <= '0;
    else ang_q <= jdzpa_pkg::ANGLE_W'(14'(jdzpa_pkg::FULL_TURN) - c_d);
    tago_q <= tag_q[N];
  end

  assign valid_o = vld_q[N+1];
  assign angle_o = ang_q;
  assign tag_o   = tago_q;
endmodule

// ----- hw/rtl/jdzpa_axis.sv -----
// One axis: dead band test, pipelined divide, rounding and saturation.
module jdzpa_axis #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  input  logic [SAMPLE_BITS-1:0]                mid_i,
  input  logic [jdzpa_pkg::BAND_W-1:0]          band_i,
  output logic                                  valid_o,
  output logic signed [jdzpa_pkg::NORM_W-1:0]   norm_o
);
  localparam int unsigned D_W   = SAMPLE_BITS + 1;
  localparam int unsigned NUM_W = SAMPLE_BITS + 16;
  localparam int unsigned Q_W   = 16 + 2;

  // stage 0: difference and band test
  logic signed [D_W+1:0] d_d, lo_d, hi_d;
  logic [SAMPLE_BITS:0]  mag_d;
  logic [NUM_W-1:0]      num_d;
  logic [D_W-1:0]        den_d;
  logic [2:0]            tag_d; // {zero, neg, mid zero}
  always_comb begin
    d_d   = (D_W+2)'($signed({2'b00, sample_i})) - (D_W+2)'($signed({2'b00, mid_i}));
    lo_d  = (D_W+2)'($signed({2'b00, mid_i})) - (D_W+2)'($signed({1'b0, band_i}));
    hi_d  = (D_W+2)'($signed({2'b00, mid_i})) + (D_W+2)'($signed({1'b0, band_i}));
    mag_d = (d_d < 0) ? (SAMPLE_BITS+1)'(-d_d) : (SAMPLE_BITS+1)'(d_d);
    // (mag * 32768 + m) / (2m)
    num_d = (NUM_W'(mag_d) << 15) + NUM_W'(mid_i);
    den_d = {mid_i, 1'b0};
    tag_d[2] = ($signed({2'b00, sample_i}) >= lo_d) && ($signed({2'b00, sample_i}) <= hi_d);
    tag_d[1] = d_d < 0;
    tag_d[0] = (mid_i == '0);
    if (tag_d[0]) den_d = D_W'(1);
  end

  logic [Q_W-1:0] q_d;
  logic [2:0]     tago_d;
  logic           vdiv_d;
  // quotient bounded: mag/m <= 2^SAMPLE_BITS so use wide enough quotient
  localparam int unsigned QF_W = SAMPLE_BITS + 16;
  logic [QF_W-1:0] qf_d;
  jdzpa_div #(.NUM_W(NUM_W), .DEN_W(D_W), .Q_W(QF_W), .TAG_W(3)) u_div (
    .clk_i, .rst_ni, .valid_i, .num_i(num_d), .den_i(den_d), .tag_i(tag_d),
    .valid_o(vdiv_d), .quot_o(qf_d), .tag_o(tago_d)
  );
  always_comb q_d = (qf_d > QF_W'(32768)) ? Q_W'(32769) : Q_W'(qf_d);

  logic                              v_q;
  logic signed [jdzpa_pkg::NORM_W-1:0] n_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= vdiv_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (tago_d[2]) n_q <= '0;
    else if (tago_d[0]) n_q <= tago_d[1] ? 16'sh8000 : 16'sh7FFF;
    else if (!tago_d[1]) n_q <= (q_d > Q_W'(32767)) ? 16'sh7FFF : 16'(q_d);
    else n_q <= (q_d > Q_W'(32768)) ? 16'sh8000 : 16'(-q_d);
  end
  assign valid_o = v_q;
  assign norm_o  = n_q;
endmodule

// ----- hw/rtl/joystick_dead_zone_polar_angle.sv -----
// Top level: joystick normaliser, clockwise polar angle and servo angles.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------
//  input     | start / busy       | in_i  (x_sample, y_sample)
//  result    | done_o (1 cycle)   | out_o (norms, polar, servo angles)
//  config    | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One item per cycle; busy is always low. An item passes (SAMPLE_BITS+16) divider
// stages, 1 saturate stage and 1 + CORDIC_STEPS (at most 24) + 1 CORDIC stages,
// as set by the bit-per-stage divider and the rotation-per-stage CORDIC.
// Servo angles are computed beside the CORDIC and delayed to match.
// Reset clears all valid bits and loads the register reset values.
// The receiver cannot stall; every item yields one result strobe.
module joystick_dead_zone_polar_angle #(
  parameter int unsigned SAMPLE_BITS  = 10,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  jdzpa_pkg::in_item_t             in_i,
  output logic                            done_o,
  output jdzpa_pkg::out_item_t            out_o,
  input  logic                            cfg_we_i,
  input  logic [jdzpa_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [jdzpa_pkg::CFG_W-1:0]     cfg_data_i
);
  localparam int unsigned LAT = ((CORDIC_STEPS < jdzpa_pkg::ATAN_N) ?
                                 CORDIC_STEPS : jdzpa_pkg::ATAN_N) + 2;

  logic [jdzpa_pkg::MID_W-1:0]  mid_x_q, mid_y_q;
  logic [jdzpa_pkg::BAND_W-1:0] band_q;
  logic [jdzpa_pkg::FREE_W-1:0] free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_x_q <= 10'd512; mid_y_q <= 10'd512; band_q <= 8'd20; free_q <= 8'd180;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jdzpa_pkg::REG_MID_X:   mid_x_q <= cfg_data_i;
        jdzpa_pkg::REG_MID_Y:   mid_y_q <= cfg_data_i;
        jdzpa_pkg::REG_DEAD:    band_q  <= cfg_data_i[jdzpa_pkg::BAND_W-1:0];
        jdzpa_pkg::REG_FREEDOM: free_q  <= cfg_data_i[jdzpa_pkg::FREE_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic go;
  assign go = start && !busy;

  // samples wider than SAMPLE_BITS are truncated; narrower zero extended
  logic [SAMPLE_BITS-1:0] xs, ys, mx, my;
  assign xs = SAMPLE_BITS'(in_i.x_sample);
  assign ys = SAMPLE_BITS'(in_i.y_sample);
  assign mx = SAMPLE_BITS'(mid_x_q);
  assign my = SAMPLE_BITS'(mid_y_q);

  logic vx, vy;
  logic signed [15:0] xn, yn;
  jdzpa_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_ax (
    .clk_i, .rst_ni, .valid_i(go), .sample_i(xs), .mid_i(mx), .band_i(band_q),
    .valid_o(vx), .norm_o(xn));
  jdzpa_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_ay (
    .clk_i, .rst_ni, .valid_i(go), .sample_i(ys), .mid_i(my), .band_i(band_q),
    .valid_o(vy), .norm_o(yn));

  // servo angle per axis, registered
  function automatic logic [12:0] servo(input logic signed [15:0] v,
                                        input logic [7:0] f);
    logic signed [26:0] p;
    logic signed [26:0] a;
    begin
      p = (27'(v) + 27'sd16384) * $signed({19'd0, f});
      a = (p + 27'sd1024) >>> 11;
      if (p <= 0) return '0;
      if (a > 27'sd6120) return 13'd6120;
      return 13'(a);
    end
  endfunction

  logic [12:0] sx_q [LAT], sy_q [LAT];
  logic signed [15:0] nx_q [LAT], ny_q [LAT];
  always_ff @(posedge clk_i) begin
    sx_q[0] <= servo(xn, free_q); sy_q[0] <= servo(yn, free_q);
    nx_q[0] <= xn; ny_q[0] <= yn;
    for (int k = 1; k < LAT; k++) begin
      sx_q[k] <= sx_q[k-1]; sy_q[k] <= sy_q[k-1];
      nx_q[k] <= nx_q[k-1]; ny_q[k] <= ny_q[k-1];
    end
  end

  logic        vc;
  logic [12:0] ang;
  logic        tag_unused;
  jdzpa_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(1)) u_cordic (
    .clk_i, .rst_ni, .valid_i(vx & vy), .x_i(xn), .y_i(yn), .tag_i(1'b0),
    .valid_o(vc), .angle_o(ang), .tag_o(tag_unused));

  assign done_o            = vc & ~tag_unused;
  assign out_o.x_norm      = nx_q[LAT-1];
  assign out_o.y_norm      = ny_q[LAT-1];
  assign out_o.polar_angle = ang;
  assign out_o.x_angle     = sx_q[LAT-1];
  assign out_o.y_angle     = sy_q[LAT-1];
endmodule

// ----- hw/rtl/jdzpa_checker.sv -----
// Port checker for the joystick block, bound to the top level.
module jdzpa_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 busy,
  input logic                 done_o,
  input jdzpa_pkg::out_item_t out_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_o.polar_angle < 13'd5760) else $error("polar out of range");
  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.x_angle <= 13'd6120 && out_o.y_angle <= 13'd6120))
    else $error("servo out of range");
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.y_norm == '0 && out_o.x_norm >= 0) |-> out_o.polar_angle == '0)
    else $error("zero angle");
endmodule

bind joystick_dead_zone_polar_angle jdzpa_checker u_chk (
  .clk_i, .rst_ni, .busy, .done_o, .out_o);
